### rtl/lfrx_pkg.sv
package lfrx_pkg;

  localparam int unsigned PosW = 9;

  localparam logic [PosW-1:0] POS_TYPE     = PosW'(12);
  localparam logic [PosW-1:0] POS_ZERO     = PosW'(13);
  localparam logic [PosW-1:0] POS_PROTOCOL = PosW'(14);
  localparam logic [PosW-1:0] POS_CONTROL  = PosW'(15);
  localparam logic [PosW-1:0] POS_NUMBER   = PosW'(16);
  localparam logic [PosW-1:0] POS_LENGTH   = PosW'(17);
  localparam logic [PosW-1:0] POS_DATA     = PosW'(18);
  localparam logic [PosW-1:0] POS_MAX      = PosW'(511);

  localparam logic [7:0] TYPE_BASE  = 8'h30;
  localparam logic [7:0] PROTO_R    = 8'h52;

  localparam logic [7:0] CTRL_STX  = 8'd2;
  localparam logic [7:0] CTRL_EOT  = 8'd4;
  localparam logic [7:0] CTRL_ENQ  = 8'd5;
  localparam logic [7:0] CTRL_ACK  = 8'd6;
  localparam logic [7:0] CTRL_NACK = 8'd21;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ST_IGNORED   = 2'd0,
    ST_ACCEPTED  = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_TRUNCATED = 2'd3
  } lfrx_status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } lfrx_byte_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   payload;
    lfrx_status_e status;
    logic [7:0]   control;
    logic [7:0]   protocol;
    logic [7:0]   number;
    logic         send;
    logic         nack;
    logic [7:0]   computed;
    logic [7:0]   received;
    logic         good;
  } lfrx_result_t;

endpackage

### rtl/lfrx_in_stage.sv
module lfrx_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  lfrx_pkg::lfrx_byte_t data_i,
  input  logic               advance_i,
  output logic               valid_o,
  output lfrx_pkg::lfrx_byte_t data_o
);
  import lfrx_pkg::*;

  logic       valid_q, valid_d;
  lfrx_byte_t data_q;

  // The held byte moves on in the same cycle that a new one arrives.
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/lfrx_frame.sv
module lfrx_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  lfrx_pkg::lfrx_byte_t data_i,
  input  logic [7:0]           group_i,
  output logic                 has_result_o,
  output lfrx_pkg::lfrx_result_t result_o
);
  import lfrx_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            tm_q, tm_d, tm_u;
  logic [7:0]      prot_q, prot_d, prot_u;
  logic [7:0]      ctrl_q, ctrl_d, ctrl_u;
  logic [7:0]      num_q, num_d, num_u;
  logic [7:0]      len_q, len_d, len_u;
  logic [7:0]      xor_q, xor_d, xor_u;
  logic [7:0]      chk_q, chk_d, chk_u;
  logic            seen_q, seen_d, seen_u;

  logic [PosW-1:0] check_pos;
  logic [7:0]      b;
  logic [7:0]      comp_raw;
  logic [7:0]      comp;
  logic            emit;
  lfrx_result_t    res;

  assign b         = data_i.rx_byte;
  assign check_pos = POS_DATA + PosW'(len_q);

  // Header capture and the running block check, as the byte position dictates.
  always_comb begin
    tm_u   = tm_q;
    prot_u = prot_q;
    ctrl_u = ctrl_q;
    num_u  = num_q;
    len_u  = len_q;
    xor_u  = xor_q;
    chk_u  = chk_q;
    seen_u = seen_q;
    emit   = 1'b0;
    if (pos_q == POS_TYPE) begin
      tm_u = (b == 8'(TYPE_BASE + group_i));
    end else if (pos_q == POS_ZERO) begin
      tm_u = tm_q && (b == 8'd0);
    end else if (pos_q == POS_PROTOCOL) begin
      prot_u = b;
    end else if (pos_q == POS_CONTROL) begin
      ctrl_u = b;
    end else if (pos_q == POS_NUMBER) begin
      num_u = b;
    end else if (pos_q == POS_LENGTH) begin
      len_u = b;
    end else if (pos_q >= POS_DATA && !seen_q) begin
      if (pos_q < check_pos) begin
        xor_u = xor_q ^ b;
        emit  = tm_q && (ctrl_q == CTRL_STX);
      end else if (pos_q == check_pos) begin
        chk_u  = b;
        seen_u = 1'b1;
      end
    end
  end

  // A zero-length frame checks against its own check byte; 0 and 255 read as 1.
  assign comp_raw = (len_u == 8'd0) ? chk_u : xor_u;
  assign comp     = (comp_raw == 8'd0 || comp_raw == 8'hFF) ? 8'd1 : comp_raw;

  always_comb begin
    res          = '0;
    res.status   = ST_IGNORED;
    has_result_o = 1'b0;
    if (!data_i.frame_end) begin
      if (emit) begin
        has_result_o = 1'b1;
        res.kind     = KIND_DATA;
        res.payload  = b;
      end
    end else begin
      has_result_o = 1'b1;
      res.kind     = KIND_VERDICT;
      if (pos_q < POS_ZERO || !tm_u) begin
        res.status = ST_IGNORED;
      end else if (pos_q < POS_NUMBER) begin
        res.status = ST_TRUNCATED;
        if (pos_q >= POS_PROTOCOL) begin
          res.protocol = prot_u;
        end
        if (pos_q >= POS_CONTROL) begin
          res.control = ctrl_u;
        end
      end else begin
        res.status   = ST_ACCEPTED;
        res.control  = ctrl_u;
        res.protocol = prot_u;
        res.number   = num_u;
        case (ctrl_u) inside
          CTRL_ENQ: begin
            res.send = 1'b1;
          end
          CTRL_EOT: begin
            res.send = (prot_u == PROTO_R);
          end
          CTRL_ACK, CTRL_NACK: begin
          end
          CTRL_STX: begin
            if (!seen_u) begin
              res.status = ST_TRUNCATED;
            end else begin
              res.computed = comp;
              res.received = chk_u;
              res.send     = 1'b1;
              res.good     = (comp == chk_u);
              res.nack     = (comp != chk_u);
            end
          end
          default: begin
            res.status = ST_UNKNOWN;
          end
        endcase
      end
    end
  end

  assign result_o = res;

  // The end mark returns every per-frame register to zero.
  always_comb begin
    pos_d  = pos_q;
    tm_d   = tm_q;
    prot_d = prot_q;
    ctrl_d = ctrl_q;
    num_d  = num_q;
    len_d  = len_q;
    xor_d  = xor_q;
    chk_d  = chk_q;
    seen_d = seen_q;
    if (fire_i) begin
      if (data_i.frame_end) begin
        pos_d  = '0;
        tm_d   = 1'b0;
        prot_d = '0;
        ctrl_d = '0;
        num_d  = '0;
        len_d  = '0;
        xor_d  = '0;
        chk_d  = '0;
        seen_d = 1'b0;
      end else begin
        pos_d  = (pos_q == POS_MAX) ? pos_q : pos_q + PosW'(1);
        tm_d   = tm_u;
        prot_d = prot_u;
        ctrl_d = ctrl_u;
        num_d  = num_u;
        len_d  = len_u;
        xor_d  = xor_u;
        chk_d  = chk_u;
        seen_d = seen_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      tm_q   <= 1'b0;
      prot_q <= '0;
      ctrl_q <= '0;
      num_q  <= '0;
      len_q  <= '0;
      xor_q  <= '0;
      chk_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      tm_q   <= tm_d;
      prot_q <= prot_d;
      ctrl_q <= ctrl_d;
      num_q  <= num_d;
      len_q  <= len_d;
      xor_q  <= xor_d;
      chk_q  <= chk_d;
      seen_q <= seen_d;
    end
  end

endmodule

### rtl/lfrx_out_reg.sv
module lfrx_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  lfrx_pkg::lfrx_result_t result_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output lfrx_pkg::lfrx_result_t result_o
);
  import lfrx_pkg::*;

  logic         valid_q, valid_d;
  lfrx_result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### rtl/link_frame_receiver_xor_check.sv
// Receives basic-mode link frames one byte per transfer, with an end mark on
// the last byte, and checks the XOR block check of STX frames. Data bytes of a
// matching STX frame come out as they arrive (result_kind 0), and the last byte
// of every frame yields one verdict (result_kind 1) with status, header echo
// and the ACK/NACK reply decision; bytes that cause neither give no result.
// The block takes one byte in every cycle while the output side is ready: a byte
// passes an input register, the frame state updates, and the result lands in an
// output register. Either side may stall without losing a transfer.
// group_number is written through the cfg channel, which is always ready and
// should only be written while no frame is in flight.
module link_frame_receiver_xor_check (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [1:0] frame_status_o,
  output logic [7:0] control_code_o,
  output logic [7:0] protocol_char_o,
  output logic [7:0] frame_number_o,
  output logic       send_reply_o,
  output logic       reply_is_nack_o,
  output logic [7:0] computed_check_o,
  output logic [7:0] received_check_o,
  output logic       payload_good_o
);
  import lfrx_pkg::*;

  logic [7:0]   group_q, group_d;
  lfrx_byte_t   in_data;
  lfrx_byte_t   stage_data;
  logic         stage_valid;
  logic         out_free;
  logic         fire;
  logic         has_result;
  lfrx_result_t frame_result;
  lfrx_result_t out_result;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    group_d = group_q;
    if (cfg_valid_i) begin
      group_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
    end else begin
      group_q <= group_d;
    end
  end

  assign in_data.rx_byte   = rx_byte_i;
  assign in_data.frame_end = frame_end_i;

  // A held byte is processed once the output register can take what it yields.
  assign fire = stage_valid && out_free;

  lfrx_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .data_i    (in_data),
    .advance_i (out_free),
    .valid_o   (stage_valid),
    .data_o    (stage_data)
  );

  lfrx_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_i       (stage_data),
    .group_i      (group_q),
    .has_result_o (has_result),
    .result_o     (frame_result)
  );

  lfrx_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && has_result),
    .result_i (frame_result),
    .free_o   (out_free),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign result_kind_o    = out_result.kind;
  assign payload_byte_o   = out_result.payload;
  assign frame_status_o   = out_result.status;
  assign control_code_o   = out_result.control;
  assign protocol_char_o  = out_result.protocol;
  assign frame_number_o   = out_result.number;
  assign send_reply_o     = out_result.send;
  assign reply_is_nack_o  = out_result.nack;
  assign computed_check_o = out_result.computed;
  assign received_check_o = out_result.received;
  assign payload_good_o   = out_result.good;

endmodule

### bench/tb_top.sv
module tb_top;
  import lfrx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseBytes = 40;

  typedef enum logic [2:0] {
    DATA_RAND, DATA_ALL00, DATA_ALLFF, DATA_XOR00, DATA_XORFF
  } data_mode_e;

  typedef enum logic [1:0] {
    CHK_GOOD, CHK_BAD, CHK_BYTE00, CHK_BYTEFF
  } chk_mode_e;

  // One frame to send: len cuts the frame to that many bytes (0 keeps it whole).
  typedef struct packed {
    logic [11:0]  len;
    logic [11:0]  extra;
    logic         type_ok;
    logic [7:0]   zero_b;
    logic [7:0]   proto;
    logic [7:0]   ctrl;
    logic [7:0]   num;
    logic [7:0]   dlen;
    data_mode_e   data_mode;
    chk_mode_e    chk_mode;
    logic         typed;
    lfrx_result_t want;
  } frame_t;

  logic       clk = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       frame_end = 1'b0;
  logic       out_ready = 1'b0;

  logic       cfg_ready_o, in_ready_o, out_valid_o;
  logic       result_kind_o, send_reply_o, reply_is_nack_o, payload_good_o;
  logic [1:0] frame_status_o;
  logic [7:0] payload_byte_o, control_code_o, protocol_char_o, frame_number_o;
  logic [7:0] computed_check_o, received_check_o;

  // Receiver state as the bench sees it.
  logic [7:0] group_cfg = 8'h00;
  logic [8:0] rx_pos = '0;
  logic       rx_type_ok = 1'b0;
  logic [7:0] rx_proto = 8'h00;
  logic [7:0] rx_ctrl = 8'h00;
  logic [7:0] rx_num = 8'h00;
  logic [7:0] rx_len = 8'h00;
  logic [7:0] rx_xor = 8'h00;
  logic [7:0] rx_check = 8'h00;
  logic       rx_check_seen = 1'b0;

  lfrx_result_t expected_results[$];
  logic [7:0]   frame_bytes[$];
  frame_t       plan[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  stall_pct = 0;

  link_frame_receiver_xor_check dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte),
    .frame_end_i      (frame_end),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .result_kind_o    (result_kind_o),
    .payload_byte_o   (payload_byte_o),
    .frame_status_o   (frame_status_o),
    .control_code_o   (control_code_o),
    .protocol_char_o  (protocol_char_o),
    .frame_number_o   (frame_number_o),
    .send_reply_o     (send_reply_o),
    .reply_is_nack_o  (reply_is_nack_o),
    .computed_check_o (computed_check_o),
    .received_check_o (received_check_o),
    .payload_good_o   (payload_good_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] fold_check(input logic [7:0] v);
    return (v == 8'h00 || v == 8'hFF) ? 8'h01 : v;
  endfunction

  // Advances the receiver state by one byte; returns 1 when the byte yields a result.
  function automatic bit predict_byte(input logic [7:0] b, input logic e,
                                      output lfrx_result_t r);
    logic [PosW-1:0] p;
    logic [PosW-1:0] check_at;
    bit              pass_data;
    logic [7:0]      comp;
    p = rx_pos;
    check_at = POS_DATA + PosW'(rx_len);
    pass_data = 1'b0;
    r = '0;
    if (p == POS_TYPE) begin
      rx_type_ok = (b == 8'(TYPE_BASE + group_cfg));
    end else if (p == POS_ZERO) begin
      rx_type_ok = rx_type_ok && (b == 8'h00);
    end else if (p == POS_PROTOCOL) begin
      rx_proto = b;
    end else if (p == POS_CONTROL) begin
      rx_ctrl = b;
    end else if (p == POS_NUMBER) begin
      rx_num = b;
    end else if (p == POS_LENGTH) begin
      rx_len = b;
    end else if (p >= POS_DATA && !rx_check_seen) begin
      if (p < check_at) begin
        rx_xor ^= b;
        pass_data = rx_type_ok && (rx_ctrl == CTRL_STX);
      end else if (p == check_at) begin
        rx_check = b;
        rx_check_seen = 1'b1;
      end
    end
    if (rx_pos < POS_MAX) rx_pos++;

    if (!e) begin
      if (pass_data) begin
        r.kind = KIND_DATA;
        r.payload = b;
      end
      return pass_data;
    end

    r.kind = KIND_VERDICT;
    if (p < POS_ZERO || !rx_type_ok) begin
      r.status = ST_IGNORED;
    end else if (p < POS_NUMBER) begin
      r.status = ST_TRUNCATED;
      if (p >= POS_PROTOCOL) r.protocol = rx_proto;
      if (p >= POS_CONTROL) r.control = rx_ctrl;
    end else begin
      r.status = ST_ACCEPTED;
      r.control = rx_ctrl;
      r.protocol = rx_proto;
      r.number = rx_num;
      case (rx_ctrl)
        CTRL_ENQ: r.send = 1'b1;
        CTRL_EOT: r.send = (rx_proto == PROTO_R);
        CTRL_ACK, CTRL_NACK: ;
        CTRL_STX: begin
          if (!rx_check_seen) begin
            r.status = ST_TRUNCATED;
          end else begin
            // An empty block checks against its own check byte.
            comp = fold_check(rx_len == 8'h00 ? rx_check : rx_xor);
            r.computed = comp;
            r.received = rx_check;
            r.send = 1'b1;
            if (comp == rx_check) r.good = 1'b1;
            else r.nack = 1'b1;
          end
        end
        default: r.status = ST_UNKNOWN;
      endcase
    end
    rx_pos = '0;
    rx_type_ok = 1'b0;
    rx_proto = 8'h00;
    rx_ctrl = 8'h00;
    rx_num = 8'h00;
    rx_len = 8'h00;
    rx_xor = 8'h00;
    rx_check = 8'h00;
    rx_check_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic frame_t mk(input int len, input int extra, input logic type_ok,
                                input logic [7:0] zb, input logic [7:0] proto,
                                input logic [7:0] ctrl, input logic [7:0] num,
                                input logic [7:0] dlen, input data_mode_e dm,
                                input chk_mode_e cm);
    frame_t f;
    f.len = 12'(len);
    f.extra = 12'(extra);
    f.type_ok = type_ok;
    f.zero_b = zb;
    f.proto = proto;
    f.ctrl = ctrl;
    f.num = num;
    f.dlen = dlen;
    f.data_mode = dm;
    f.chk_mode = cm;
    f.typed = 1'b0;
    f.want = '0;
    return f;
  endfunction

  function automatic frame_t typed_row(input frame_t f, input lfrx_result_t w);
    f.typed = 1'b1;
    f.want = w;
    return f;
  endfunction

  function automatic lfrx_result_t verdict(input lfrx_status_e st, input logic [7:0] ctrl,
                                           input logic [7:0] proto, input logic [7:0] num,
                                           input logic send);
    lfrx_result_t r;
    r = '0;
    r.kind = KIND_VERDICT;
    r.status = st;
    r.control = ctrl;
    r.protocol = proto;
    r.number = num;
    r.send = send;
    return r;
  endfunction

  function automatic frame_t rand_frame();
    frame_t     f;
    int         r;
    logic [7:0] ctrl;
    logic [7:0] proto;
    logic [7:0] dlen;
    data_mode_e dm;
    chk_mode_e  cm;
    int         len;
    int         extra;
    r = $urandom_range(0, 99);
    ctrl = (r < 50) ? CTRL_STX : (r < 60) ? CTRL_ENQ : (r < 70) ? CTRL_EOT :
           (r < 77) ? CTRL_ACK : (r < 84) ? CTRL_NACK : 8'($urandom);
    proto = ($urandom_range(0, 9) < 3) ? PROTO_R : 8'($urandom);
    r = $urandom_range(0, 99);
    dlen = (r < 85) ? 8'($urandom_range(0, 16)) :
           (r < 97) ? 8'($urandom_range(17, 64)) : 8'($urandom_range(200, 255));
    r = $urandom_range(0, 99);
    dm = (r < 70) ? DATA_RAND : (r < 78) ? DATA_XOR00 : (r < 86) ? DATA_XORFF :
         (r < 93) ? DATA_ALL00 : DATA_ALLFF;
    r = $urandom_range(0, 99);
    cm = (r < 70) ? CHK_GOOD : (r < 88) ? CHK_BAD : (r < 94) ? CHK_BYTE00 : CHK_BYTEFF;
    len = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 20 + int'(dlen)) : 0;
    extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    f = mk(len, extra, $urandom_range(0, 99) < 92,
           ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
           proto, ctrl, 8'($urandom), dlen, dm, cm);
    // Now and then a short burst of line noise instead of a frame.
    if ($urandom_range(0, 99) < 5) begin
      f.type_ok = 1'b0;
      f.len = 12'($urandom_range(1, 30));
    end
    return f;
  endfunction

  function automatic void build_frame(input frame_t f);
    logic [7:0] acc;
    logic [7:0] d;
    logic [7:0] c;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(f.type_ok ? 8'(TYPE_BASE + group_cfg) :
                          8'(TYPE_BASE + group_cfg + 8'($urandom_range(1, 255))));
    frame_bytes.push_back(f.zero_b);
    frame_bytes.push_back(f.proto);
    frame_bytes.push_back(f.ctrl);
    frame_bytes.push_back(f.num);
    if (f.ctrl == CTRL_STX) begin
      frame_bytes.push_back(f.dlen);
      acc = 8'h00;
      for (int i = 0; i < int'(f.dlen); i++) begin
        case (f.data_mode)
          DATA_ALL00: d = 8'h00;
          DATA_ALLFF: d = 8'hFF;
          default:    d = 8'($urandom);
        endcase
        // The last byte can steer the running XOR onto a value that gets forced.
        if (i == int'(f.dlen) - 1 && f.data_mode == DATA_XOR00) d = acc;
        if (i == int'(f.dlen) - 1 && f.data_mode == DATA_XORFF) d = acc ^ 8'hFF;
        acc ^= d;
        frame_bytes.push_back(d);
      end
      c = fold_check(acc);
      case (f.chk_mode)
        CHK_GOOD:   if (f.dlen == 8'h00) c = 8'($urandom_range(1, 254));
        CHK_BAD:    c = (f.dlen == 8'h00) ? (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF) :
                        c ^ 8'($urandom_range(1, 255));
        CHK_BYTE00: c = 8'h00;
        CHK_BYTEFF: c = 8'hFF;
      endcase
      frame_bytes.push_back(c);
    end
    repeat (int'(f.extra)) frame_bytes.push_back(8'($urandom));
    if (f.len != 0) begin
      while (frame_bytes.size() > int'(f.len)) void'(frame_bytes.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                           input lfrx_result_t want);
    lfrx_result_t r;
    int unsigned  gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                   $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_end <= e;
    if (predict_byte(b, e, r)) expected_results.push_back((typed && e) ? want : r);
    do @(negedge clk); while (!in_ready_o);
    @(posedge clk);
  endtask

  task automatic send_frame(input frame_t f);
    build_frame(f);
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, f.typed, f.want);
    end
  endtask

  // Waits until the receiver has nothing in flight, then writes the group.
  task automatic set_group(input logic [7:0] g);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(negedge clk); while (!cfg_ready_o);
    @(posedge clk);
    cfg_valid <= 1'b0;
    group_cfg = g;
  endtask

  // The result side stalls in runs, with a stall rate that changes over time.
  always @(posedge clk) begin
    if (cycles % 200 == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 50;
      endcase
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin : result_monitor
    lfrx_result_t got;
    lfrx_result_t wanted;
    if (rst_ni && out_valid_o && out_ready) begin
      got = '0;
      got.kind = result_kind_o;
      got.payload = payload_byte_o;
      got.status = lfrx_status_e'(frame_status_o);
      got.control = control_code_o;
      got.protocol = protocol_char_o;
      got.number = frame_number_o;
      got.send = send_reply_o;
      got.nack = reply_is_nack_o;
      got.computed = computed_check_o;
      got.received = received_check_o;
      got.good = payload_good_o;
      if (expected_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result at cycle %0d: kind %0d payload %h status %0d",
                   cycles, got.kind, got.payload, got.status);
        end
        mismatches++;
      end else begin
        wanted = expected_results.pop_front();
        if (got.kind !== wanted.kind || got.payload !== wanted.payload ||
            got.status !== wanted.status || got.control !== wanted.control ||
            got.protocol !== wanted.protocol || got.number !== wanted.number ||
            got.send !== wanted.send || got.nack !== wanted.nack ||
            got.computed !== wanted.computed || got.received !== wanted.received ||
            got.good !== wanted.good) begin
          if (mismatches < 10) begin
            $display("result mismatch at cycle %0d (expected/actual): kind %0d/%0d %s",
                     cycles, wanted.kind, got.kind, "");
            $display("  payload %h/%h status %0d/%0d control %h/%h protocol %h/%h",
                     wanted.payload, got.payload, wanted.status, got.status,
                     wanted.control, got.control, wanted.protocol, got.protocol);
            $display("  number %h/%h send %0d/%0d nack %0d/%0d", wanted.number,
                     got.number, wanted.send, got.send, wanted.nack, got.nack);
            $display("  computed %h/%h received %h/%h good %0d/%0d", wanted.computed,
                     got.computed, wanted.received, got.received, wanted.good, got.good);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    frame_t      f;
    logic [7:0]  phase_groups[5];
    int unsigned counted;

    // Directed frames, all built while the group is 0.
    plan.push_back(typed_row(mk(0, 0, 1'b1, 8'h00, PROTO_R, CTRL_ENQ, 8'h00, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_ACCEPTED, CTRL_ENQ, PROTO_R, 8'h00, 1'b1)));
    plan.push_back(typed_row(mk(0, 0, 1'b1, 8'h00, PROTO_R, CTRL_EOT, 8'hFF, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_ACCEPTED, CTRL_EOT, PROTO_R, 8'hFF, 1'b1)));
    plan.push_back(typed_row(mk(0, 0, 1'b1, 8'h00, 8'h00, CTRL_EOT, 8'h07, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_ACCEPTED, CTRL_EOT, 8'h00, 8'h07, 1'b0)));
    plan.push_back(typed_row(mk(0, 0, 1'b1, 8'h00, 8'hFF, CTRL_ACK, 8'h01, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_ACCEPTED, CTRL_ACK, 8'hFF, 8'h01, 1'b0)));
    plan.push_back(typed_row(mk(0, 2, 1'b1, 8'h00, PROTO_R, CTRL_NACK, 8'h80, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_ACCEPTED, CTRL_NACK, PROTO_R, 8'h80, 1'b0)));
    plan.push_back(typed_row(mk(0, 0, 1'b1, 8'h00, 8'h41, 8'hFF, 8'h02, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_UNKNOWN, 8'hFF, 8'h41, 8'h02, 1'b0)));
    plan.push_back(typed_row(mk(0, 0, 1'b1, 8'h00, 8'h41, 8'h00, 8'h03, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_UNKNOWN, 8'h00, 8'h41, 8'h03, 1'b0)));
    // Wrong type byte, nonzero byte 13, and frames that end before byte 13.
    plan.push_back(typed_row(mk(0, 0, 1'b0, 8'h00, PROTO_R, CTRL_ENQ, 8'h04, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_IGNORED, 8'h00, 8'h00, 8'h00, 1'b0)));
    plan.push_back(typed_row(mk(0, 0, 1'b1, 8'h80, PROTO_R, CTRL_ENQ, 8'h05, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_IGNORED, 8'h00, 8'h00, 8'h00, 1'b0)));
    plan.push_back(typed_row(mk(6, 0, 1'b1, 8'h00, PROTO_R, CTRL_ENQ, 8'h06, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_IGNORED, 8'h00, 8'h00, 8'h00, 1'b0)));
    plan.push_back(typed_row(mk(13, 0, 1'b1, 8'h00, PROTO_R, CTRL_ENQ, 8'h06, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_IGNORED, 8'h00, 8'h00, 8'h00, 1'b0)));
    // Type matches but the header is cut short.
    plan.push_back(typed_row(mk(14, 0, 1'b1, 8'h00, PROTO_R, CTRL_ENQ, 8'h06, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_TRUNCATED, 8'h00, 8'h00, 8'h00, 1'b0)));
    plan.push_back(typed_row(mk(15, 0, 1'b1, 8'h00, 8'h41, CTRL_ENQ, 8'h06, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_TRUNCATED, 8'h00, 8'h41, 8'h00, 1'b0)));
    plan.push_back(typed_row(mk(16, 0, 1'b1, 8'h00, 8'h41, CTRL_ENQ, 8'h06, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_TRUNCATED, CTRL_ENQ, 8'h41, 8'h00, 1'b0)));
    // A long tail pushes the byte counter into saturation.
    plan.push_back(typed_row(mk(0, 500, 1'b1, 8'h00, 8'h10, CTRL_ENQ, 8'h20, 8'h00,
                                DATA_RAND, CHK_GOOD),
                             verdict(ST_ACCEPTED, CTRL_ENQ, 8'h10, 8'h20, 1'b1)));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h09, 8'd4, DATA_RAND,
                      CHK_GOOD));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h0A, 8'd3, DATA_RAND,
                      CHK_BAD));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, 8'h00, CTRL_STX, 8'h0B, 8'd0, DATA_RAND,
                      CHK_GOOD));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, 8'hFF, CTRL_STX, 8'h0C, 8'd0, DATA_RAND,
                      CHK_BYTE00));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, 8'h41, CTRL_STX, 8'h0D, 8'd0, DATA_RAND,
                      CHK_BYTEFF));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'hFF, 8'd255, DATA_ALLFF,
                      CHK_GOOD));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h00, 8'd6, DATA_XOR00,
                      CHK_GOOD));
    plan.push_back(mk(0, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h0E, 8'd5, DATA_XORFF,
                      CHK_BAD));
    plan.push_back(mk(0, 3, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h0F, 8'd2, DATA_ALL00,
                      CHK_GOOD));
    // STX frames that end on a data byte, on the length byte and on the number byte.
    plan.push_back(mk(20, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h11, 8'd5, DATA_RAND,
                      CHK_GOOD));
    plan.push_back(mk(18, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h12, 8'd5, DATA_RAND,
                      CHK_GOOD));
    plan.push_back(mk(17, 0, 1'b1, 8'h00, PROTO_R, CTRL_STX, 8'h13, 8'd5, DATA_RAND,
                      CHK_GOOD));

    phase_groups = '{8'd207, 8'($urandom_range(1, 206)), 8'd0,
                     8'($urandom_range(0, 207)), 8'd207};

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    set_group(8'd0);
    foreach (plan[i]) send_frame(plan[i]);

    foreach (phase_groups[ph]) begin
      set_group(phase_groups[ph]);
      counted = 0;
      while (counted < PhaseBytes) begin
        f = rand_frame();
        send_frame(f);
        if (f.type_ok && f.zero_b == 8'h00) counted += frame_bytes.size();
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lfrx_pkg.sv
rtl/lfrx_in_stage.sv
rtl/lfrx_frame.sv
rtl/lfrx_out_reg.sv
rtl/link_frame_receiver_xor_check.sv
bench/tb_top.sv
